/* design/spv_pkg.sv */
// Shared types and constants for the sine PWM driver.
// Depends on nothing; the top level and the checker import it.
`default_nettype none

package spv_pkg;

	localparam int DEF_TABLE_DIVISOR = 18;
	localparam int TABLE_LEN         = 15;

	localparam int WORD_W   = 16;
	localparam int VAL_W    = 12;
	localparam int SEL_W    = 4;
	localparam int AMP_W    = 7;
	localparam int FREQ_W   = 9;
	localparam int UNIT_W   = 9;
	localparam int DUTY_W   = 16;
	localparam int PERIOD_W = 16;
	localparam int PHASE_W  = 6;
	localparam int IDX_W    = 4;
	localparam int SINE_W   = 15;
	localparam int INNER_W  = 23;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SPI  = 1'b1;

	localparam logic [SEL_W-1:0] SEL_AMP  = 4'h1;
	localparam logic [SEL_W-1:0] SEL_FREQ = 4'h2;

	localparam logic [VAL_W-1:0]    AMP_MAX    = 12'd100;
	localparam logic [VAL_W-1:0]    FREQ_MAX   = 12'd500;
	localparam logic [PERIOD_W-1:0] PERIOD_NUM = 16'd35333;
	localparam logic [INNER_W-1:0]  DUTY_BIAS  = 23'd3276800;

	localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 16'd117;
	localparam logic [AMP_W-1:0]    RST_AMP         = 7'd100;
	localparam logic [FREQ_W-1:0]   RST_FREQ        = 9'd300;
	localparam logic [UNIT_W-1:0]   RST_UNIT        = 9'd100;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_AMP,
		ST_MUL_UNIT,
		ST_DIV,
		ST_FINISH
	} spv_state_t;

endpackage

`default_nettype wire

/* design/spv_serial_mul.sv */
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// Depends on nothing; shared by both duty products of the top level.
`default_nettype none

module spv_serial_mul #(
	parameter int A_W = 23,
	parameter int B_W = 9
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [A_W-1:0]     a,
	input  wire logic [B_W-1:0]     b,
	output logic                    done,
	output logic [A_W+B_W-1:0]      prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] prod_q;
	logic [A_W:0]       sum;

	// add the multiplicand into the upper half when the current multiplier bit is set
	assign sum = {1'b0, prod_q[A_W+B_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : {(A_W+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(B_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_W{1'b0}}, b};
		end else if (cnt_q != '0) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

/* design/spv_serial_div.sv */
// Restoring divider: one quotient bit per cycle, MSB first.
// Depends on nothing; turns a new frequency into a step period.
`default_nettype none

module spv_serial_div #(
	parameter int N_W = 16,
	parameter int D_W = 9
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [N_W-1:0] dividend,
	input  wire logic [D_W-1:0] divisor,
	output logic                done,
	output logic [N_W-1:0]      quot
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   d_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             fits;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign fits  = (trial >= {1'b0, d_q});
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// shift the dividend out of the quotient register while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

`default_nettype wire

/* design/sine_pwm_vibration_driver.sv */
// Sine PWM vibration driver: top level with control sequencer, state and quarter-sine table.
// Depends on spv_pkg, spv_serial_mul and spv_serial_div.
//
// Usage:
//   Input channel (in_valid / in_stall, opcode, spi_word) carries one transaction per
//   microsecond tick (opcode 0) or per received SPI command word (opcode 1).
//   Output channel (out_valid / out_stall) returns exactly one transaction per input:
//   the held duty count, the echoed command value and two flags saying what changed.
//   cfg_we / cfg_data write duty_unit; write it only while the block is idle.
// Sequence, one transaction at a time:
//   - a tick that does not expire the step period, or any command that leaves the
//     frequency as it is: straight from idle to the finish state, which loads the output register.
//   - a tick that advances the phase: two passes through the bit-serial multiplier
//     (sine * amplitude, then duty_unit * bias term), then the finish state.
//   - a frequency change: the 16-step serial divider for 35333 / freq, then the finish state.
//   The next input is taken as soon as the sequencer is back in idle, even while the
//   previous result still sits in the output register.
// Reset: amplitude 100, frequency 300, step period 117, duty_unit 100, phase 0,
//   duty and reply hold 0, no result pending.
// Stall: a stalled result holds in the output register; a finished computation waits
//   in its last step until that register frees up, and the input stays stalled meanwhile.
`default_nettype none

module sine_pwm_vibration_driver #(
	parameter int TABLE_DIVISOR = spv_pkg::DEF_TABLE_DIVISOR
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [spv_pkg::UNIT_W-1:0]    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          opcode,
	input  wire logic [spv_pkg::WORD_W-1:0]    spi_word,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [spv_pkg::DUTY_W-1:0]         duty_value,
	output logic                               duty_updated,
	output logic [spv_pkg::VAL_W-1:0]          reply_word,
	output logic                               reply_updated
);

	import spv_pkg::*;

	localparam int MUL_A_W = INNER_W;
	localparam int MUL_B_W = UNIT_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [PHASE_W-1:0] PH_QUARTER   = 6'd15;
	localparam logic [PHASE_W-1:0] PH_HALF      = 6'd30;
	localparam logic [PHASE_W-1:0] PH_3QUARTER  = 6'd45;
	localparam logic [PHASE_W-1:0] PH_END_Q1    = 6'd29;
	localparam logic [PHASE_W-1:0] PH_END_Q3    = 6'd59;
	localparam logic [PHASE_W-1:0] PH_SKIP_A    = 6'd14;
	localparam logic [PHASE_W-1:0] PH_SKIP_B    = 6'd29;
	localparam logic [PHASE_W-1:0] PH_SKIP_C    = 6'd44;
	localparam logic [PHASE_W-1:0] PH_COUNT     = 6'd60;
	localparam logic [PHASE_W-1:0] PH_WRAP      = 6'd1;
	localparam logic [PHASE_W-1:0] IDX_LAST     = 6'(TABLE_LEN - 1);

	// quarter-sine table, fixed at elaboration from the table divisor
	logic [SINE_W-1:0] sine_tab [TABLE_LEN];

	for (genvar gi = 0; gi < TABLE_LEN; gi++) begin : g_tab
		// Q30 Taylor series of sin(x), nine terms, each truncated; rounded half up to Q15
		localparam logic [63:0] X_I  = (HALF_PI_Q30 * 64'(gi)) / 64'(TABLE_DIVISOR);
		localparam logic [63:0] X2_I = (X_I * X_I) >> 30;
		localparam logic [63:0] T1_I = ((X_I * X2_I) >> 30) / 64'd6;
		localparam logic [63:0] T2_I = ((T1_I * X2_I) >> 30) / 64'd20;
		localparam logic [63:0] T3_I = ((T2_I * X2_I) >> 30) / 64'd42;
		localparam logic [63:0] T4_I = ((T3_I * X2_I) >> 30) / 64'd72;
		localparam logic [63:0] T5_I = ((T4_I * X2_I) >> 30) / 64'd110;
		localparam logic [63:0] T6_I = ((T5_I * X2_I) >> 30) / 64'd156;
		localparam logic [63:0] T7_I = ((T6_I * X2_I) >> 30) / 64'd210;
		localparam logic [63:0] T8_I = ((T7_I * X2_I) >> 30) / 64'd272;
		localparam logic [63:0] POS_I = X_I + T2_I + T4_I + T6_I + T8_I;
		localparam logic [63:0] NEG_I = T1_I + T3_I + T5_I + T7_I;
		localparam logic [63:0] R_I = (NEG_I > POS_I) ? 64'd0
		                                              : (((POS_I - NEG_I) + 64'd16384) >> 15);
		localparam logic [SINE_W-1:0] S_I = (R_I > 64'd32767) ? SINE_W'(32767) : SINE_W'(R_I);
		assign sine_tab[gi] = S_I;
	end

	spv_state_t state_q, state_d;

	logic [PHASE_W-1:0]  phase_q;
	logic [PERIOD_W-1:0] tick_count_q;
	logic [PERIOD_W-1:0] step_period_q;
	logic [AMP_W-1:0]    amplitude_q;
	logic [FREQ_W-1:0]   frequency_q;
	logic [UNIT_W-1:0]   duty_unit_q;
	logic [DUTY_W-1:0]   duty_hold_q;
	logic [VAL_W-1:0]    reply_hold_q;
	logic                neg_q;
	logic                dupd_q;
	logic                rupd_q;

	logic                out_valid_q;
	logic [DUTY_W-1:0]   duty_value_q;
	logic                duty_updated_q;
	logic [VAL_W-1:0]    reply_word_q;
	logic                reply_updated_q;

	// decode of the incoming transaction
	logic                accept;
	logic [PERIOD_W-1:0] tick_inc;
	logic                expire;
	logic [SEL_W-1:0]    sel;
	logic [VAL_W-1:0]    val;
	logic [AMP_W-1:0]    amp_c;
	logic [FREQ_W-1:0]   freq_c;
	logic                freq_change;

	// waveform lookup
	logic [PHASE_W-1:0]  off;
	logic                neg_d;
	logic [IDX_W-1:0]    tab_idx;
	logic [PHASE_W-1:0]  phase_step;
	logic [PHASE_W-1:0]  phase_sum;
	logic [PHASE_W-1:0]  phase_next;

	// arithmetic units
	logic                mul_start;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic                mul_done;
	logic [PROD_W-1:0]   mul_prod;
	logic [INNER_W-1:0]  inner;
	logic [DUTY_W:0]     duty_raw;
	logic [DUTY_W-1:0]   duty_sat;
	logic                div_start;
	logic                div_done;
	logic [PERIOD_W-1:0] div_quot;
	logic                load_out;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	assign tick_inc = tick_count_q + 1'b1;
	assign expire   = (tick_inc >= step_period_q);

	assign sel = spi_word[WORD_W-1:WORD_W-SEL_W];
	assign val = spi_word[VAL_W-1:0];

	// clamp amplitude to 100 and frequency to 1..500
	always_comb begin
		amp_c = (val > AMP_MAX) ? AMP_MAX[AMP_W-1:0] : val[AMP_W-1:0];
		if (val > FREQ_MAX) begin
			freq_c = FREQ_MAX[FREQ_W-1:0];
		end else if (val == '0) begin
			freq_c = FREQ_W'(1);
		end else begin
			freq_c = val[FREQ_W-1:0];
		end
	end
	assign freq_change = (freq_c != frequency_q);

	// mirror the quarter table across the four quadrants
	always_comb begin
		if (phase_q < PH_QUARTER) begin
			off   = phase_q;
			neg_d = 1'b0;
		end else if (phase_q < PH_HALF) begin
			off   = PH_END_Q1 - phase_q;
			neg_d = 1'b0;
		end else if (phase_q < PH_3QUARTER) begin
			off   = phase_q - PH_HALF;
			neg_d = 1'b1;
		end else begin
			off   = PH_END_Q3 - phase_q;
			neg_d = 1'b1;
		end
		tab_idx = (off > IDX_LAST) ? IDX_LAST[IDX_W-1:0] : off[IDX_W-1:0];
	end

	// skip 15, 30 and 45, which repeat the table entry of the phase before; wrap to 1
	assign phase_step = (phase_q == PH_SKIP_A || phase_q == PH_SKIP_B || phase_q == PH_SKIP_C)
		? PHASE_W'(2) : PHASE_W'(1);
	assign phase_sum  = phase_q + phase_step;
	assign phase_next = (phase_sum >= PH_COUNT) ? PH_WRAP : phase_sum;

	assign inner    = neg_q ? (DUTY_BIAS - mul_prod[INNER_W-1:0])
	                        : (DUTY_BIAS + mul_prod[INNER_W-1:0]);
	assign duty_raw = mul_prod[PROD_W-1:PROD_W-DUTY_W-1];
	assign duty_sat = duty_raw[DUTY_W] ? {DUTY_W{1'b1}} : duty_raw[DUTY_W-1:0];

	// sequencer: next state and unit control
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_TICK) begin
						if (expire) begin
							// first pass: sine * amplitude
							mul_start = 1'b1;
							mul_a     = MUL_A_W'(sine_tab[tab_idx]);
							mul_b     = MUL_B_W'(amplitude_q);
							state_d   = ST_MUL_AMP;
						end else begin
							state_d = ST_FINISH;
						end
					end else if (sel == SEL_FREQ && freq_change) begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_MUL_AMP: begin
				if (mul_done) begin
					// second pass: duty_unit * (bias +/- product)
					mul_start = 1'b1;
					mul_a     = inner;
					mul_b     = duty_unit_q;
					state_d   = ST_MUL_UNIT;
				end
			end
			ST_MUL_UNIT: begin
				if (mul_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= '0;
			tick_count_q  <= '0;
			step_period_q <= RST_STEP_PERIOD;
			amplitude_q   <= RST_AMP;
			frequency_q   <= RST_FREQ;
			duty_unit_q   <= RST_UNIT;
			duty_hold_q   <= '0;
			reply_hold_q  <= '0;
			neg_q         <= 1'b0;
			dupd_q        <= 1'b0;
			rupd_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				duty_unit_q <= cfg_data;
			end
			if (accept) begin
				if (opcode == OP_TICK) begin
					dupd_q       <= expire;
					rupd_q       <= 1'b0;
					tick_count_q <= expire ? '0 : tick_inc;
					if (expire) begin
						neg_q   <= neg_d;
						phase_q <= phase_next;
					end
				end else begin
					dupd_q <= 1'b0;
					rupd_q <= (sel == SEL_AMP) || (sel == SEL_FREQ);
					if (sel == SEL_AMP) begin
						amplitude_q  <= amp_c;
						reply_hold_q <= val;
					end
					if (sel == SEL_FREQ) begin
						reply_hold_q <= val;
						if (freq_change) begin
							frequency_q  <= freq_c;
							tick_count_q <= '0;
						end
					end
				end
			end
			if (state_q == ST_MUL_UNIT && mul_done) begin
				duty_hold_q <= duty_sat;
			end
			if (state_q == ST_DIV && div_done) begin
				step_period_q <= div_quot;
			end
		end
	end

	// output register: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			duty_value_q    <= duty_hold_q;
			duty_updated_q  <= dupd_q;
			reply_word_q    <= reply_hold_q;
			reply_updated_q <= rupd_q;
		end
	end

	spv_serial_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	spv_serial_div #(
		.N_W (PERIOD_W),
		.D_W (FREQ_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (PERIOD_NUM),
		.divisor  (freq_c),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign out_valid     = out_valid_q;
	assign duty_value    = duty_value_q;
	assign duty_updated  = duty_updated_q;
	assign reply_word    = reply_word_q;
	assign reply_updated = reply_updated_q;

endmodule

`default_nettype wire

/* design/spv_checker.sv */
// Port-level checker for the sine PWM driver, bound to the top level.
// Depends on spv_pkg; watches the top-level ports only.
`default_nettype none

module spv_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [spv_pkg::DUTY_W-1:0]    duty_value,
	input wire logic                          duty_updated,
	input wire logic [spv_pkg::VAL_W-1:0]     reply_word,
	input wire logic                          reply_updated
);

	import spv_pkg::*;

	logic [DUTY_W-1:0] last_duty_q;
	logic [VAL_W-1:0]  last_reply_q;

	// track the values carried by the last delivered transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_duty_q  <= '0;
			last_reply_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_duty_q  <= duty_value;
			last_reply_q <= reply_word;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_value) && $stable(reply_word))
		else $error("stalled result changed");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result presented right after reset");

	a_duty_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !duty_updated |-> duty_value == last_duty_q)
		else $error("duty changed without a phase step");

	a_reply_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_updated |-> reply_word == last_reply_q)
		else $error("reply changed without a command");

	a_one_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(duty_updated && reply_updated))
		else $error("tick and command reported in one transaction");

endmodule

bind sine_pwm_vibration_driver spv_checker u_spv_checker (.*);

`default_nettype wire
